### rtl/pfsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Packet field rewriter package
// Shared types, codes and constants for the packet field rewriter.
// ----------------------------------------------------------------------------
package pfsr_pkg;

  localparam int NUM_RULES_DEF    = 16;
  localparam int BUFFER_BYTES_DEF = 2048;
  localparam int QUEUE_DEPTH      = 4;

  localparam int OFFSET_W = 11;

  // Request modes on the input channel.
  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Status codes of an add request.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd2;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd3;
  localparam logic [2:0] ST_MIN_MAX    = 3'd4;

  localparam logic [31:0] LIMIT_1B   = 32'h0000_00ff;
  localparam logic [31:0] LIMIT_2B   = 32'h0000_ffff;
  localparam logic [31:0] LIMIT_4B   = 32'hffff_ffff;
  localparam logic [31:0] RANGE_FULL = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_ADD,
    OP_CLEAR,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [7:0]          data_byte;
    logic                last_byte;
    logic                end_of_batch;
    logic [OFFSET_W-1:0] field_offset;
    logic [7:0]          field_size;
    logic [31:0]         field_min;
    logic [31:0]         field_max;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [2:0] status;
  } out_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    op_kind_t            kind;
    logic [7:0]          data_byte;
    logic                last_byte;
    logic                end_of_batch;
    logic [2:0]          status;
    logic [OFFSET_W-1:0] field_offset;
    logic [2:0]          field_size;
    logic [31:0]         field_min;
    logic [31:0]         field_range;
  } op_t;

endpackage
`default_nettype wire

### rtl/pfsr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Packet field rewriter front end
// Classifies requests, tracks the byte position and checks add requests.
// ----------------------------------------------------------------------------
module pfsr_front #(
  parameter int NUM_RULES    = pfsr_pkg::NUM_RULES_DEF,
  parameter int BUFFER_BYTES = pfsr_pkg::BUFFER_BYTES_DEF,
  parameter int POS_W        = $clog2(BUFFER_BYTES),
  parameter int CNT_W        = $clog2(NUM_RULES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pfsr_pkg::in_t in_data,
  input  wire logic          accept,
  output pfsr_pkg::op_t      op,
  output logic [POS_W-1:0]   op_pos
);
  import pfsr_pkg::*;

  localparam int OW    = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;
  localparam int SUM_W = OW + 1;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      limit;
  logic [31:0]      lo_c;
  logic [31:0]      hi_c;
  logic [31:0]      span;
  logic [SUM_W-1:0] end_pos;
  logic             size_ok;
  logic [2:0]       add_status;

  always_comb begin
    size_ok = 1'b1;
    limit   = LIMIT_4B;
    case (in_data.field_size)
      8'd1:    limit = LIMIT_1B;
      8'd2:    limit = LIMIT_2B;
      8'd4:    limit = LIMIT_4B;
      default: size_ok = 1'b0;
    endcase
    lo_c    = (in_data.field_min > limit) ? limit : in_data.field_min;
    hi_c    = (in_data.field_max > limit) ? limit : in_data.field_max;
    span    = hi_c - lo_c + 32'd1;
    end_pos = SUM_W'(in_data.field_offset) + SUM_W'(in_data.field_size);

    if (cnt_r >= CNT_W'(NUM_RULES)) begin
      add_status = ST_FULL;
    end else if (!size_ok) begin
      add_status = ST_BAD_SIZE;
    end else if (end_pos > SUM_W'(BUFFER_BYTES)) begin
      add_status = ST_BAD_OFFSET;
    end else if (lo_c > hi_c) begin
      add_status = ST_MIN_MAX;
    end else begin
      add_status = ST_OK;
    end
  end

  always_comb begin
    op              = '0;
    op.data_byte    = in_data.data_byte;
    op.last_byte    = in_data.last_byte;
    op.end_of_batch = in_data.end_of_batch;
    op.field_offset = in_data.field_offset;
    op.field_size   = in_data.field_size[2:0];
    op.field_min    = lo_c;
    op.field_range  = (span == 32'd0) ? RANGE_FULL : span;
    op_pos          = pos_r;
    pos_nxt         = pos_r;
    cnt_nxt         = cnt_r;
    case (in_data.mode)
      MODE_BYTE: begin
        op.kind = OP_BYTE;
        if (in_data.last_byte) begin
          pos_nxt = '0;
        end else if (pos_r != POS_W'(BUFFER_BYTES - 1)) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      MODE_ADD: begin
        op.kind   = OP_ADD;
        op.status = add_status;
        if (add_status == ST_OK) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      MODE_CLEAR: begin
        op.kind = OP_CLEAR;
        cnt_nxt = '0;
      end
      default: begin
        op.kind = OP_NOP;
      end
    endcase
  end

  // The front keeps its own copy of the rule count; requests stay in order,
  // so it always agrees with the back end once the queue drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/pfsr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Packet field rewriter request queue
// Small in-order queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pfsr_queue #(
  parameter int W     = 8,
  parameter int DEPTH = pfsr_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  import pfsr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0] level_r;

  assign full  = (level_r == LVL_W'(DEPTH));
  assign empty = (level_r == '0);
  assign dout  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + LVL_W'(1);
      end else if (pop && !push) begin
        level_r <= level_r - LVL_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/pfsr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Packet field rewriter back end
// Holds the rule table, rewrites packet bytes and advances the counters.
// ----------------------------------------------------------------------------
module pfsr_back #(
  parameter int NUM_RULES = pfsr_pkg::NUM_RULES_DEF,
  parameter int POS_W     = $clog2(pfsr_pkg::BUFFER_BYTES_DEF),
  parameter int CNT_W     = $clog2(NUM_RULES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              op_valid,
  input  wire pfsr_pkg::op_t     op,
  input  wire logic [POS_W-1:0]  op_pos,
  output logic                   op_pop,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output pfsr_pkg::out_t         out_data
);
  import pfsr_pkg::*;

  localparam int RIW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int OW  = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;

  logic [POS_W-1:0] off_r [NUM_RULES];
  logic [2:0]       size_r [NUM_RULES];
  logic [31:0]      min_r [NUM_RULES];
  logic [31:0]      rng_r [NUM_RULES];
  logic [31:0]      ctr_r [NUM_RULES];
  // Current field value, min plus counter, kept alongside the counter.
  logic [31:0]      val_r [NUM_RULES];

  logic [CNT_W-1:0]     cnt_r;
  logic [NUM_RULES-1:0] live;
  logic [NUM_RULES-1:0] hit;
  logic [7:0]           sel [NUM_RULES];
  logic [OW-1:0]        off_w;
  logic                 wr_en;
  logic                 adv;
  logic [7:0]           byte_v;
  logic                 out_valid_r;
  out_t                 out_r;
  out_t                 res;

  assign op_pop = op_valid && (!out_valid_r || out_ready);
  assign wr_en  = op_pop && (op.kind == OP_ADD) && (op.status == ST_OK);
  assign adv    = op_pop && (op.kind == OP_BYTE) && op.last_byte && op.end_of_batch;
  assign off_w  = OW'(op.field_offset);

  for (genvar i = 0; i < NUM_RULES; i++) begin : g_rule
    logic [POS_W-1:0] d;
    logic [1:0]       sh;
    logic [2:0]       size_m1;

    assign live[i]  = (CNT_W'(i) < cnt_r);
    assign d        = op_pos - off_r[i];
    assign size_m1  = size_r[i] - 3'd1;
    assign sh       = size_m1[1:0] - d[1:0];
    assign hit[i]   = (op_pos >= off_r[i]) && (d < POS_W'(size_r[i]));

    always_comb begin
      case (sh)
        2'd0:    sel[i] = val_r[i][7:0];
        2'd1:    sel[i] = val_r[i][15:8];
        2'd2:    sel[i] = val_r[i][23:16];
        default: sel[i] = val_r[i][31:24];
      endcase
    end

    always_ff @(posedge clk) begin
      if (wr_en && (cnt_r[RIW-1:0] == RIW'(i))) begin
        off_r[i]  <= off_w[POS_W-1:0];
        size_r[i] <= op.field_size;
        min_r[i]  <= op.field_min;
        rng_r[i]  <= op.field_range;
        ctr_r[i]  <= '0;
        val_r[i]  <= op.field_min;
      end else if (adv && live[i]) begin
        if (ctr_r[i] + 32'd1 == rng_r[i]) begin
          ctr_r[i] <= '0;
          val_r[i] <= min_r[i];
        end else begin
          ctr_r[i] <= ctr_r[i] + 32'd1;
          val_r[i] <= val_r[i] + 32'd1;
        end
      end
    end
  end

  // Later rules override earlier ones where fields overlap.
  always_comb begin
    byte_v = op.data_byte;
    for (int i = 0; i < NUM_RULES; i++) begin
      if (live[i] && hit[i]) begin
        byte_v = sel[i];
      end
    end
  end

  always_comb begin
    res = '0;
    case (op.kind)
      OP_BYTE: begin
        res.out_byte = byte_v;
        res.out_last = op.last_byte;
      end
      OP_ADD: begin
        res.status = op.status;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (wr_en) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (op_pop && (op.kind == OP_CLEAR)) begin
      cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### rtl/packet_field_sequential_rewriter.sv
`default_nettype none
// An accepted request is written into the queue; the back end pops it and
// registers its result in the output register, which offers it.
// Throughput: one request per cycle, sustained unless the output stalls; the
// back end matches a packet byte against all rules combinationally.
// A four-entry queue lets the input keep flowing while the output stalls.
// Reset: synchronous, active low; clears the rule count, byte position,
// queue and output valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Packet field rewriter
// Rewrites packet bytes that fall inside configured fields with counter values.
// ----------------------------------------------------------------------------
module packet_field_sequential_rewriter #(
  parameter int NUM_RULES    = pfsr_pkg::NUM_RULES_DEF,
  parameter int BUFFER_BYTES = pfsr_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pfsr_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pfsr_pkg::out_t     out_data
);
  import pfsr_pkg::*;

  localparam int POS_W = $clog2(BUFFER_BYTES);
  localparam int CNT_W = $clog2(NUM_RULES + 1);
  localparam int OP_W  = $bits(op_t);
  localparam int Q_W   = OP_W + POS_W;

  op_t              f_op;
  logic [POS_W-1:0] f_pos;
  op_t              b_op;
  logic [POS_W-1:0] b_pos;
  logic [Q_W-1:0]   q_dout;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  pfsr_front #(
    .NUM_RULES    (NUM_RULES),
    .BUFFER_BYTES (BUFFER_BYTES),
    .POS_W        (POS_W),
    .CNT_W        (CNT_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .accept  (accept),
    .op      (f_op),
    .op_pos  (f_pos)
  );

  pfsr_queue #(
    .W     (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   ({f_pos, f_op}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign b_op  = op_t'(q_dout[OP_W-1:0]);
  assign b_pos = q_dout[Q_W-1 -: POS_W];

  pfsr_back #(
    .NUM_RULES (NUM_RULES),
    .POS_W     (POS_W),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (!q_empty),
    .op        (b_op),
    .op_pos    (b_pos),
    .op_pop    (q_pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### rtl/pfsr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Packet field rewriter checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pfsr_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire pfsr_pkg::out_t out_data
);
  import pfsr_pkg::*;

  // A stalled result must be held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // The queue is empty after reset, so requests are taken at once.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  // Only add requests report a status, and they carry no byte.
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.out_byte == 8'd0) && !out_data.out_last)
    else $error("failed add carries byte data");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= ST_MIN_MAX))
    else $error("status code out of range");

endmodule

bind packet_field_sequential_rewriter pfsr_checker u_pfsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

### tb/packet_field_sequential_rewriter_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Packet field rewriter testbench
// Loads field rules, streams packets through the rewriter and checks every
// result against a cycle-free model of the rule table, byte position and
// batch counters. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module packet_field_sequential_rewriter_tb;
  import pfsr_pkg::*;

  localparam int NRULES     = NUM_RULES_DEF;
  localparam int BUF_BYTES  = BUFFER_BYTES_DEF;
  localparam int CLK_PERIOD = 12;
  localparam int MAX_CYCLES = 1000000;
  localparam logic [1:0] MODE_IDLE = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  packet_field_sequential_rewriter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Rule table, counters and packet position as the block should hold them.
  logic [4:0]          rule_cnt;
  logic [OFFSET_W-1:0] rule_off  [NRULES];
  logic [2:0]          rule_size [NRULES];
  logic [31:0]         rule_base [NRULES];
  logic [31:0]         rule_span [NRULES];
  logic [31:0]         rule_ctr  [NRULES];
  logic [OFFSET_W-1:0] pkt_pos;

  out_t rewritten_q[$];

  bit burst;
  bit hold_active;
  int hold_len;
  int mismatches;
  int results_seen;
  int n_bytes;
  int n_adds;
  int n_adds_ok;
  int n_clears;
  int n_ignored;
  int n_wraps;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * MAX_CYCLES);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [2:0] add_rule(in_t r);
    logic [31:0] limit;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] span;
    int          idx;
    if (int'(rule_cnt) >= NRULES) return ST_FULL;
    case (r.field_size)
      8'd1: limit = LIMIT_1B;
      8'd2: limit = LIMIT_2B;
      8'd4: limit = LIMIT_4B;
      default: return ST_BAD_SIZE;
    endcase
    if (int'(r.field_offset) + int'(r.field_size) > BUF_BYTES) return ST_BAD_OFFSET;
    lo = (r.field_min > limit) ? limit : r.field_min;
    hi = (r.field_max > limit) ? limit : r.field_max;
    if (lo > hi) return ST_MIN_MAX;
    span = hi - lo + 32'd1;
    if (span == 32'd0) span = RANGE_FULL;
    idx = int'(rule_cnt);
    rule_off[idx]  = r.field_offset;
    rule_size[idx] = r.field_size[2:0];
    rule_base[idx] = lo;
    rule_span[idx] = span;
    rule_ctr[idx]  = 32'd0;
    rule_cnt       = rule_cnt + 5'd1;
    n_adds_ok++;
    return ST_OK;
  endfunction

  function automatic logic [7:0] rewrite_byte(logic [7:0] b);
    logic [7:0]  res;
    logic [31:0] v;
    int          i;
    int          pos;
    int          off;
    int          sz;
    int          lane;
    res = b;
    pos = int'(pkt_pos);
    for (i = 0; i < NRULES; i++) begin
      if (i < int'(rule_cnt)) begin
        off = int'(rule_off[i]);
        sz  = int'(rule_size[i]);
        // Later rules overwrite earlier ones, so the last hit wins.
        if (pos >= off && pos < off + sz) begin
          v    = rule_base[i] + rule_ctr[i];
          lane = sz - 1 - (pos - off);
          res  = v[8*lane +: 8];
        end
      end
    end
    return res;
  endfunction

  function automatic void advance_counters();
    int i;
    for (i = 0; i < NRULES; i++) begin
      if (i < int'(rule_cnt)) begin
        rule_ctr[i] = rule_ctr[i] + 32'd1;
        if (rule_ctr[i] == rule_span[i]) begin
          rule_ctr[i] = 32'd0;
          n_wraps++;
        end
      end
    end
  endfunction

  function automatic out_t rewrite_step(in_t r);
    out_t o;
    o = '0;
    case (r.mode)
      MODE_BYTE: begin
        o.out_byte = rewrite_byte(r.data_byte);
        o.out_last = r.last_byte;
        if (r.last_byte) begin
          pkt_pos = '0;
          if (r.end_of_batch) advance_counters();
        end else if (int'(pkt_pos) + 1 < BUF_BYTES) begin
          pkt_pos = pkt_pos + 1'b1;
        end
      end
      MODE_ADD:   o.status = add_rule(r);
      MODE_CLEAR: rule_cnt = '0;
      default: ;
    endcase
    return o;
  endfunction

  // ------------------------------------------------------ request builders

  // Every field random, so unused fields toggle too.
  function automatic in_t noise_req();
    logic [95:0] raw;
    in_t         r;
    raw = {$urandom(), $urandom(), $urandom()};
    r   = raw[$bits(in_t)-1:0];
    return r;
  endfunction

  function automatic in_t byte_req(logic [7:0] d, logic last, logic eob);
    in_t r;
    r              = noise_req();
    r.mode         = MODE_BYTE;
    r.data_byte    = d;
    r.last_byte    = last;
    r.end_of_batch = eob;
    return r;
  endfunction

  function automatic in_t add_req(int off, int size, logic [31:0] lo, logic [31:0] hi);
    in_t r;
    r              = noise_req();
    r.mode         = MODE_ADD;
    r.field_offset = off[OFFSET_W-1:0];
    r.field_size   = size[7:0];
    r.field_min    = lo;
    r.field_max    = hi;
    return r;
  endfunction

  function automatic in_t clear_req();
    in_t r;
    r      = noise_req();
    r.mode = MODE_CLEAR;
    return r;
  endfunction

  // Mostly legal rules with narrow ranges so counters wrap often.
  function automatic in_t rand_add(int max_off);
    logic [31:0] mask;
    logic [31:0] lo;
    logic [31:0] hi;
    int          size;
    int          pick;
    pick = $urandom_range(0, 99);
    size = (pick < 30) ? 1 : (pick < 60) ? 2 : (pick < 90) ? 4 : $urandom_range(0, 255);
    mask = (size == 1) ? LIMIT_1B : (size == 2) ? LIMIT_2B : LIMIT_4B;
    lo   = ($urandom_range(0, 4) == 0) ? $urandom() : ($urandom() & mask);
    pick = $urandom_range(0, 99);
    if (pick < 75)      hi = lo + $urandom_range(0, 4);
    else if (pick < 90) hi = $urandom();
    else                hi = mask;
    return add_req($urandom_range(0, max_off), size, lo, hi);
  endfunction

  function automatic int pick_gap();
    int pick;
    if (burst) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ------------------------------------------------------------- channels

  task automatic send_req(input in_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(negedge clk); while (in_ready !== 1'b1);
    @(posedge clk);
    rewritten_q.push_back(rewrite_step(r));
    case (r.mode)
      MODE_BYTE:  n_bytes++;
      MODE_ADD:   n_adds++;
      MODE_CLEAR: n_clears++;
      default:    n_ignored++;
    endcase
  endtask

  task automatic send_packet(input int len, input logic eob);
    int i;
    for (i = 0; i < len; i++)
      send_req(byte_req(8'($urandom_range(0, 255)), i == len - 1,
                        (i == len - 1) ? eob : logic'($urandom_range(0, 1))));
  endtask

  // The sender goes idle and waits until every expected result is back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (rewritten_q.size() != 0);
  endtask

  // Result side: random stalls, a requested long hold-off, or always ready.
  initial begin
    int pick;
    out_ready   = 1'b0;
    hold_active = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len    = 0;
        hold_active = 1'b0;
      end else if (burst) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else if (pick < 94) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  task automatic note_mismatch(input string what, input out_t exp, input out_t act);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch (%s): expected byte %02h last %0d status %0d, ",
                "got byte %02h last %0d status %0d"},
               what, exp.out_byte, exp.out_last, exp.status,
               act.out_byte, act.out_last, act.status);
  endtask

  // Handshake signals are stable at the falling edge, so a result seen here
  // is the one taken at the next rising edge.
  initial begin
    out_t exp;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
        results_seen++;
        if (rewritten_q.size() == 0) begin
          note_mismatch("nothing pending", '0, out_data);
        end else begin
          exp = rewritten_q.pop_front();
          if (out_data.out_byte !== exp.out_byte || out_data.out_last !== exp.out_last ||
              out_data.status !== exp.status)
            note_mismatch("field", exp, out_data);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_add_checks();
    int i;
    send_req(clear_req());
    send_req(add_req(0, 1, 32'h12, 32'h34));
    send_req(add_req(1, 2, 32'h1234, 32'h1236));
    send_req(add_req(3, 4, 32'h0, 32'hffff_ffff));          // full 32-bit range
    send_req(add_req(7, 0, 32'h0, 32'h1));
    send_req(add_req(7, 3, 32'h0, 32'h1));
    send_req(add_req(7, 255, 32'h0, 32'h1));
    send_req(add_req(2047, 2, 32'h0, 32'h1));               // one byte past the end
    send_req(add_req(2044, 4, 32'h0, 32'h1));               // ends exactly at the end
    send_req(add_req(8, 1, 32'h50, 32'h40));
    send_req(add_req(8, 1, 32'h1234, 32'h12));              // min clamps above max
    send_req(add_req(8, 1, 32'h300, 32'h400));              // both clamp to 0xff
    send_req(add_req(9, 2, 32'h1_0000, 32'h2_0000));
    for (i = int'(rule_cnt); i < NRULES; i++)
      send_req(add_req(16 + i, 1, i, i + 1));
    send_req(add_req(0, 3, 32'h5, 32'h1));                  // full beats bad size
    send_req(add_req(0, 1, 32'h0, 32'h1));
  endtask

  task automatic test_rewrite();
    int i;
    send_req(clear_req());
    send_req(add_req(0, 4, 32'hdead_beef, 32'hdead_bef0));
    send_req(add_req(2, 1, 32'h7f, 32'h80));                // overlaps, later wins
    send_req(add_req(5, 2, 32'hfffe, 32'hffff));
    send_req(add_req(6, 1, 32'h0, 32'h0));                  // range of one
    for (i = 0; i < 3; i++) begin
      send_req(byte_req(8'h00, 1'b0, 1'b1));                // batch end without last
      send_req(byte_req(8'hff, 1'b0, 1'b0));
      send_packet(6, 1'b1);
    end
    send_req(byte_req(8'ha5, 1'b1, 1'b0));                  // last without batch end
    send_req(add_req(0, 1, 32'h0, 32'h1) | in_t'({MODE_IDLE, 93'd0}));
    send_packet(8, 1'b1);
  endtask

  task automatic test_long_packet();
    send_req(clear_req());
    send_req(add_req(0, 1, 32'h0, 32'hff));
    send_req(add_req(250, 2, 32'ha5a5, 32'ha5a6));
    send_packet(300, 1'b1);                                 // field deep in the packet
    send_packet(260, 1'b1);
    send_packet(4, 1'b0);
  endtask

  task automatic test_backpressure();
    int i;
    send_req(clear_req());
    send_req(add_req(1, 2, 32'h100, 32'h102));
    send_req(add_req(4, 4, 32'hffff_fffe, 32'hffff_ffff));
    in_valid <= 1'b0;
    burst    = 1'b1;
    hold_len = 150;
    @(posedge clk);
    wait (hold_active);
    for (i = 0; i < 4; i++) send_packet(10, 1'b1);
    burst = 1'b0;
    drain();
    for (i = 0; i < 4; i++) send_packet($urandom_range(1, 12), 1'b1);
  endtask

  task automatic test_random(input int budget);
    int start;
    int pick;
    int n;
    int i;
    start = n_bytes + n_adds + n_clears;
    while (n_bytes + n_adds + n_clears - start < budget) begin
      burst = ($urandom_range(0, 9) == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 72) begin
        if (int'(rule_cnt) >= 14 || $urandom_range(0, 6) == 0) send_req(clear_req());
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) send_req(rand_add(40));
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++)
          send_packet(($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 48),
                      logic'($urandom_range(0, 1)));
      end else if (pick < 96) begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) send_req(noise_req());
      end else begin
        drain();
      end
    end
    burst = 1'b0;
  endtask

  initial begin
    int i;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    burst    = 1'b0;
    hold_len = 0;
    rule_cnt = '0;
    pkt_pos  = '0;
    for (i = 0; i < NRULES; i++) begin
      rule_off[i]  = '0;
      rule_size[i] = '0;
      rule_base[i] = '0;
      rule_span[i] = '0;
      rule_ctr[i]  = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_add_checks();
    test_rewrite();
    test_long_packet();
    test_backpressure();
    test_random(900);

    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d packet bytes, %0d rule adds (%0d accepted), %0d clears, %0d ignored.",
             n_bytes, n_adds, n_adds_ok, n_clears, n_ignored);
    $display("Checked %0d results, saw %0d counter wraps, %0d mismatches.",
             results_seen, n_wraps, mismatches);
    if (mismatches == 0 && rewritten_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
